// File: hdl/wdl_pkg.sv
package wdl_pkg;

    // String capacity and the widths that follow from it.
    localparam int MAX_LEN   = 64;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int ROW_SPAN  = 2 ** LEN_W;
    localparam int ROW_DEPTH = 3 * ROW_SPAN;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);

    // A cell never exceeds MAX_LEN * (insert + delete); one weight on top still fits.
    localparam int COST_W    = $clog2(2 * MAX_LEN * 256 + 256);

    localparam int CHAR_W    = 8;
    localparam int WEIGHT_W  = 8;
    localparam int DIST_W    = 16;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int WIDE_W    = (COST_W > DIST_W) ? COST_W : DIST_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_COMPUTE       = 2'd2,
        CMD_NONE          = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWAP   = 2'd0,
        REG_SUBST  = 2'd1,
        REG_INSERT = 2'd2,
        REG_DELETE = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_CELL,
        ST_DONE
    } t_state;

    typedef logic [1:0] t_row;

    typedef struct packed {
        logic [WEIGHT_W-1:0] swap;
        logic [WEIGHT_W-1:0] subst;
        logic [WEIGHT_W-1:0] ins;
        logic [WEIGHT_W-1:0] del;
    } t_weights;

    typedef struct packed {
        logic [COST_W-1:0] diag;
        logic [COST_W-1:0] up;
        logic [COST_W-1:0] older;
        logic [COST_W-1:0] left;
        logic [CHAR_W-1:0] fi;
        logic [CHAR_W-1:0] fim1;
        logic [CHAR_W-1:0] sj;
        logic [CHAR_W-1:0] sjm1;
        logic              swap_ok;
    } t_cell_in;

    function automatic logic [DIST_W-1:0] saturate_dist(input logic [COST_W-1:0] cost);
        logic [WIDE_W-1:0] wide;
        begin
            wide = WIDE_W'(cost);
            if (wide > WIDE_W'((2 ** DIST_W) - 1)) begin
                return '1;
            end
            return wide[DIST_W-1:0];
        end
    endfunction

endpackage

// File: hdl/wdl_char_mem.sv
module wdl_char_mem
    import wdl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic [IDX_W-1:0]  i_raddr_a,
    input  logic [IDX_W-1:0]  i_raddr_b,
    output logic [CHAR_W-1:0] o_rdata_a,
    output logic [CHAR_W-1:0] o_rdata_b
);

    logic [CHAR_W-1:0] r_mem [0:MAX_LEN-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/wdl_row_mem.sv
module wdl_row_mem
    import wdl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_AW-1:0] i_waddr,
    input  logic [COST_W-1:0] i_wdata,
    input  logic [ROW_AW-1:0] i_raddr_a,
    input  logic [ROW_AW-1:0] i_raddr_b,
    output logic [COST_W-1:0] o_rdata_a,
    output logic [COST_W-1:0] o_rdata_b
);

    // Three cost rows, each on a power-of-two boundary so that an address is {row, column}.
    logic [COST_W-1:0] r_mem [0:ROW_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: hdl/wdl_cell_unit.sv
module wdl_cell_unit
    import wdl_pkg::*;
(
    input  t_weights          i_weights,
    input  t_cell_in          i_cell,
    output logic [COST_W-1:0] o_cost
);

    logic [COST_W-1:0] c_diag;
    logic [COST_W-1:0] c_swap;
    logic [COST_W-1:0] c_up;
    logic [COST_W-1:0] c_left;
    logic [COST_W-1:0] m_swap;
    logic [COST_W-1:0] m_up;
    logic              swap_hit;

    always_comb begin
        c_diag = i_cell.diag + ((i_cell.fi != i_cell.sj) ? COST_W'(i_weights.subst) : '0);
        c_swap = i_cell.older + COST_W'(i_weights.swap);
        c_up   = i_cell.up + COST_W'(i_weights.del);
        c_left = i_cell.left + COST_W'(i_weights.ins);

        // A swap only counts when the two adjacent characters appear crossed.
        swap_hit = i_cell.swap_ok && (i_cell.fim1 == i_cell.sj) && (i_cell.fi == i_cell.sjm1);

        m_swap = (swap_hit && (c_swap < c_diag)) ? c_swap : c_diag;
        m_up   = (c_up < m_swap) ? c_up : m_swap;
        o_cost = (c_left < m_up) ? c_left : m_up;
    end

endmodule

// File: hdl/weighted_damerau_levenshtein.sv
// Channel   Direction  Signals                                   Fields (lowest bit up)
// s_axis    in         s_axis_tvalid/tready/tdata/tuser          tdata: char_in; tuser: cmd
// m_axis    out        m_axis_tvalid/tready/tdata/tuser          tdata: distance; tuser: overflowed
// cfg       in         i_cfg_valid/o_cfg_ready/i_cfg_index/data  index 0 swap, 1 subst, 2 ins, 3 del
//
// A compute item works on the stored lengths n1 and n2: the first row of n2 + 1 columns is
// seeded one column per cycle, each of the n1 rows then writes column zero and then each of
// its cells through the shared add-compare unit, and a final step loads the result. Reset is
// synchronous and active low; weights return to one, both strings empty and the overflow flag
// clears, while the memories need no clearing pass. Input is refused during a compute; appends
// are taken while a result waits, and a further compute is taken too but holds its result until then.
module weighted_damerau_levenshtein
    import wdl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] char_in
    input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] cmd

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DIST_W-1:0]    m_axis_tdata,   // [15:0] distance
    output logic                 m_axis_tuser,   // [0] overflowed

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data
);

    // Control state.
    t_state            r_state;
    t_state            n_state;
    logic [LEN_W-1:0]  r_len_a;
    logic [LEN_W-1:0]  r_len_b;
    logic              r_drop;
    t_weights          r_weights;
    t_row              r_row_old;
    t_row              r_row_prev;
    t_row              r_row_cur;
    logic              r_out_valid;

    // Sequencer counters and datapath registers.
    logic [LEN_W-1:0]  r_i;
    logic [LEN_W-1:0]  r_j;
    logic [COST_W-1:0] r_acc;
    logic [COST_W-1:0] r_col;
    logic [COST_W-1:0] r_last;
    logic [COST_W-1:0] r_left;
    logic [COST_W-1:0] r_diag;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_ovf;

    t_cmd              in_cmd;
    logic              in_fire;
    logic              out_load;
    logic              init_end;
    logic              last_cell;
    logic              last_row;
    logic              row_end;
    logic              first_we;
    logic              second_we;
    logic [LEN_W-1:0]  j_plus1;
    logic [LEN_W-1:0]  j_plus2;
    logic [COST_W-1:0] col_next;
    logic [COST_W-1:0] cell_cost;

    logic              row_we;
    logic [ROW_AW-1:0] row_waddr;
    logic [COST_W-1:0] row_wdata;
    logic [ROW_AW-1:0] row_raddr_a;
    logic [ROW_AW-1:0] row_raddr_b;
    logic [COST_W-1:0] row_rdata_a;
    logic [COST_W-1:0] row_rdata_b;
    logic [IDX_W-1:0]  sec_raddr_a;
    logic [IDX_W-1:0]  sec_raddr_b;
    logic [CHAR_W-1:0] sec_rdata_a;
    logic [CHAR_W-1:0] sec_rdata_b;
    logic [CHAR_W-1:0] fst_rdata_a;
    logic [CHAR_W-1:0] fst_rdata_b;
    t_cell_in          cell_in;

    assign in_cmd        = t_cmd'(s_axis_tuser);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_dist;
    assign m_axis_tuser  = r_out_ovf;

    assign j_plus1   = r_j + LEN_W'(1);
    assign j_plus2   = r_j + LEN_W'(2);
    assign col_next  = r_col + COST_W'(r_weights.del);
    assign init_end  = (r_j == r_len_b);
    assign last_cell = (j_plus1 == r_len_b);
    assign last_row  = ((r_i + LEN_W'(1)) == r_len_a);
    assign row_end   = ((r_state == ST_ROW) && (r_len_b == '0)) ||
                       ((r_state == ST_CELL) && last_cell);
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    assign first_we  = in_fire && (in_cmd == CMD_APPEND_FIRST) && (r_len_a < LEN_W'(MAX_LEN));
    assign second_we = in_fire && (in_cmd == CMD_APPEND_SECOND) && (r_len_b < LEN_W'(MAX_LEN));

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && (in_cmd == CMD_COMPUTE)) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                if (init_end) begin
                    n_state = (r_len_a == '0) ? ST_DONE : ST_ROW;
                end
            end
            ST_ROW: begin
                if (r_len_b == '0) begin
                    n_state = last_row ? ST_DONE : ST_ROW;
                end else begin
                    n_state = ST_CELL;
                end
            end
            ST_CELL: begin
                if (last_cell) begin
                    n_state = last_row ? ST_DONE : ST_ROW;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory addressing per state. In a cell cycle the reads for the next cell go out
    // while the current cell is written into the row being built.
    always_comb begin
        row_we      = 1'b0;
        row_waddr   = {r_row_prev, r_j};
        row_wdata   = r_acc;
        row_raddr_a = {r_row_prev, LEN_W'(1)};
        row_raddr_b = {r_row_old, LEN_W'(0)};
        sec_raddr_a = '0;
        sec_raddr_b = '0;
        unique case (r_state)
            ST_INIT: begin
                row_we    = 1'b1;
                row_waddr = {r_row_prev, r_j};
                row_wdata = r_acc;
            end
            ST_ROW: begin
                row_we    = 1'b1;
                row_waddr = {r_row_cur, LEN_W'(0)};
                row_wdata = col_next;
            end
            ST_CELL: begin
                row_we      = 1'b1;
                row_waddr   = {r_row_cur, j_plus1};
                row_wdata   = cell_cost;
                row_raddr_a = {r_row_prev, j_plus2};
                row_raddr_b = {r_row_old, r_j};
                sec_raddr_a = j_plus1[IDX_W-1:0];
                sec_raddr_b = r_j[IDX_W-1:0];
            end
            ST_IDLE, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_drop      <= 1'b0;
            r_weights   <= '{swap: 8'd1, subst: 8'd1, ins: 8'd1, del: 8'd1};
            r_row_old   <= 2'd0;
            r_row_prev  <= 2'd1;
            r_row_cur   <= 2'd2;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_SWAP:   r_weights.swap  <= i_cfg_data;
                    REG_SUBST:  r_weights.subst <= i_cfg_data;
                    REG_INSERT: r_weights.ins   <= i_cfg_data;
                    REG_DELETE: r_weights.del   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (in_fire) begin
                unique case (in_cmd)
                    CMD_APPEND_FIRST: begin
                        if (first_we) begin
                            r_len_a <= r_len_a + LEN_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                    CMD_APPEND_SECOND: begin
                        if (second_we) begin
                            r_len_b <= r_len_b + LEN_W'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                    CMD_COMPUTE, CMD_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end

            // Rows rotate: the finished row becomes the previous one.
            if (row_end) begin
                r_row_old  <= r_row_prev;
                r_row_prev <= r_row_cur;
                r_row_cur  <= r_row_old;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_len_a     <= '0;
                r_len_b     <= '0;
                r_drop      <= 1'b0;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; r_last always holds the most recent cell written.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_j   <= '0;
                r_acc <= '0;
            end
            ST_INIT: begin
                r_last <= r_acc;
                r_acc  <= r_acc + COST_W'(r_weights.ins);
                r_j    <= j_plus1;
                r_i    <= '0;
                r_col  <= '0;
            end
            ST_ROW: begin
                r_last <= col_next;
                r_left <= col_next;
                r_diag <= r_col;
                r_col  <= col_next;
                r_j    <= '0;
                if (r_len_b == '0) begin
                    r_i <= r_i + LEN_W'(1);
                end
            end
            ST_CELL: begin
                r_last <= cell_cost;
                r_left <= cell_cost;
                r_diag <= row_rdata_a;
                if (last_cell) begin
                    r_i <= r_i + LEN_W'(1);
                end else begin
                    r_j <= j_plus1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out_dist <= saturate_dist(r_last);
                    r_out_ovf  <= r_drop;
                end
            end
            default: begin
            end
        endcase
    end

    assign cell_in = '{
        diag:    r_diag,
        up:      row_rdata_a,
        older:   row_rdata_b,
        left:    r_left,
        fi:      fst_rdata_a,
        fim1:    fst_rdata_b,
        sj:      sec_rdata_a,
        sjm1:    sec_rdata_b,
        swap_ok: (r_i != '0) && (r_j != '0)
    };

    wdl_char_mem u_first (
        .i_clk     (i_clk),
        .i_we      (first_we),
        .i_waddr   (r_len_a[IDX_W-1:0]),
        .i_wdata   (s_axis_tdata),
        .i_raddr_a (r_i[IDX_W-1:0]),
        .i_raddr_b (IDX_W'(r_i - LEN_W'(1))),
        .o_rdata_a (fst_rdata_a),
        .o_rdata_b (fst_rdata_b)
    );

    wdl_char_mem u_second (
        .i_clk     (i_clk),
        .i_we      (second_we),
        .i_waddr   (r_len_b[IDX_W-1:0]),
        .i_wdata   (s_axis_tdata),
        .i_raddr_a (sec_raddr_a),
        .i_raddr_b (sec_raddr_b),
        .o_rdata_a (sec_rdata_a),
        .o_rdata_b (sec_rdata_b)
    );

    wdl_row_mem u_rows (
        .i_clk     (i_clk),
        .i_we      (row_we),
        .i_waddr   (row_waddr),
        .i_wdata   (row_wdata),
        .i_raddr_a (row_raddr_a),
        .i_raddr_b (row_raddr_b),
        .o_rdata_a (row_rdata_a),
        .o_rdata_b (row_rdata_b)
    );

    wdl_cell_unit u_cell (
        .i_weights (r_weights),
        .i_cell    (cell_in),
        .o_cost    (cell_cost)
    );

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= LEN_W'(MAX_LEN)) && (r_len_b <= LEN_W'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL) |-> ((r_j < r_len_b) && (r_i < r_len_a)))
        else $error("cell index outside the stored strings");

    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ((r_len_a == '0) && (r_len_b == '0) && !r_drop))
        else $error("strings not cleared after a result");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared outside the final step");

endmodule
